// ----- hdl/slw_pkg.sv -----
// ----------------------------------------------------------------------------
// slw_pkg
// Shared sizes, types and helpers for the supercover line walk block.
// ----------------------------------------------------------------------------
package slw_pkg;

    // stored grid size
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(CELLS);

    // field and register widths
    localparam int COORD_W   = 6;
    localparam int CFG_W     = 7;
    localparam int COORD_MAX = (1 << COORD_W) - 1;

    // crossing time (2n+1)*a, n and a at most COORD_MAX
    localparam int TIME_W = $clog2((2 * COORD_MAX + 1) * COORD_MAX + 1);

    // compare width for bounds checks
    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int CMP_W   = (DIM_W > CFG_W) ? DIM_W : CFG_W;

    // config port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0] GRID_DIM_RESET = CFG_W'(64);

    // request kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [ADDR_W-1:0]  cell_addr_t;
    typedef logic [CFG_W-1:0]   grid_dim_t;

    // sequencer to stepping unit
    typedef struct packed {
        logic load;
        logic step_x;
        logic step_y;
    } dda_cmd_t;

    // stepping unit decision for the next boundary
    typedef struct packed {
        logic done;
        logic corner;
        logic go_x;
    } dda_view_t;

    function automatic cell_addr_t cell_addr(input coord_t x, input coord_t y);
        return ADDR_W'(int'(y) * MAX_WIDTH + int'(x));
    endfunction

    function automatic logic in_stored(input coord_t x, input coord_t y);
        return (CMP_W'(x) < CMP_W'(MAX_WIDTH)) && (CMP_W'(y) < CMP_W'(MAX_HEIGHT));
    endfunction

    function automatic logic in_area(input coord_t x, input coord_t y,
                                     input grid_dim_t gw, input grid_dim_t gh);
        return in_stored(x, y) && (CMP_W'(x) < CMP_W'(gw)) && (CMP_W'(y) < CMP_W'(gh));
    endfunction

endpackage

// ----- hdl/slw_bitmap.sv -----
// ----------------------------------------------------------------------------
// slw_bitmap
// One bit per grid cell, one write and one registered read per cycle.
// Sweeps every cell to zero after reset, ignoring writes until it is done.
// ----------------------------------------------------------------------------
module slw_bitmap (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  slw_pkg::cell_addr_t wr_addr,
    input  logic               wr_bit,
    input  slw_pkg::cell_addr_t rd_addr,
    output logic               rd_bit,
    output logic               clearing
);
    import slw_pkg::*;

    localparam cell_addr_t LAST_CELL = ADDR_W'(CELLS - 1);

    logic       mem [CELLS];
    logic       rd_bit_reg;
    logic       clr_busy_reg, clr_busy_next;
    cell_addr_t clr_cnt_reg, clr_cnt_next;

    // clearing sweep control
    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clr_busy_reg) begin
            if (clr_cnt_reg == LAST_CELL) begin
                clr_busy_next = 1'b0;
            end else begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    // storage array
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_cnt_reg] <= 1'b0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_bit;
        end
        rd_bit_reg <= mem[rd_addr];
    end

    assign rd_bit   = rd_bit_reg;
    assign clearing = clr_busy_reg;

endmodule

// ----- hdl/slw_dda.sv -----
// ----------------------------------------------------------------------------
// slw_dda
// Integer DDA stepping unit: keeps position, step counts and the running
// crossing times, and compares the next x and y crossings.
// ----------------------------------------------------------------------------
module slw_dda (
    input  logic              aclk,
    input  slw_pkg::dda_cmd_t cmd,
    input  slw_pkg::coord_t   x0,
    input  slw_pkg::coord_t   y0,
    input  slw_pkg::coord_t   x1,
    input  slw_pkg::coord_t   y1,
    output slw_pkg::coord_t   cur_x,
    output slw_pkg::coord_t   cur_y,
    output slw_pkg::coord_t   nxt_x,
    output slw_pkg::coord_t   nxt_y,
    output slw_pkg::dda_view_t view
);
    import slw_pkg::*;

    coord_t            x_reg, y_reg, nx_reg, ny_reg, ax_reg, ay_reg;
    logic              sx_neg_reg, sy_neg_reg;
    logic [TIME_W-1:0] tx_reg, ty_reg;

    logic x_left, y_left, x_first, y_first, go_x, go_y;
    coord_t ax_load, ay_load;

    // distances on load
    assign ax_load = (x1 > x0) ? (x1 - x0) : (x0 - x1);
    assign ay_load = (y1 > y0) ? (y1 - y0) : (y0 - y1);

    // neighbor cells in the stepping direction
    assign nxt_x = sx_neg_reg ? (x_reg - 1'b1) : (x_reg + 1'b1);
    assign nxt_y = sy_neg_reg ? (y_reg - 1'b1) : (y_reg + 1'b1);
    assign cur_x = x_reg;
    assign cur_y = y_reg;

    // shared crossing-time compare
    assign x_left  = nx_reg < ax_reg;
    assign y_left  = ny_reg < ay_reg;
    assign x_first = tx_reg < ty_reg;
    assign y_first = ty_reg < tx_reg;
    assign go_x    = x_left && (!y_left || x_first);
    assign go_y    = y_left && (!x_left || y_first);

    assign view.done   = !x_left && !y_left;
    assign view.corner = (x_left || y_left) && !go_x && !go_y;
    assign view.go_x   = go_x;

    // position and crossing-time update
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg      <= x0;
            y_reg      <= y0;
            nx_reg     <= '0;
            ny_reg     <= '0;
            ax_reg     <= ax_load;
            ay_reg     <= ay_load;
            sx_neg_reg <= !(x1 > x0);
            sy_neg_reg <= !(y1 > y0);
            tx_reg     <= TIME_W'(ay_load);
            ty_reg     <= TIME_W'(ax_load);
        end else begin
            if (cmd.step_x) begin
                x_reg  <= nxt_x;
                nx_reg <= nx_reg + 1'b1;
                tx_reg <= tx_reg + TIME_W'({ay_reg, 1'b0});
            end
            if (cmd.step_y) begin
                y_reg  <= nxt_y;
                ny_reg <= ny_reg + 1'b1;
                ty_reg <= ty_reg + TIME_W'({ax_reg, 1'b0});
            end
        end
    end

endmodule

// ----- hdl/supercover_line_walkable.sv -----
// ----------------------------------------------------------------------------
// supercover_line_walkable
// Walkable-cell bitmap with a supercover line-of-walk query.
// ----------------------------------------------------------------------------
// After reset the bitmap is swept to all walls, one cell a cycle, with s_ready
// low; the config port works during the sweep. A cell write (kind 0) gives no
// result. A query (kind 1) reads the bitmap once per cell probed, each probe
// passing through the registered read port (S_READ, then S_CHECK): probes are
// 1 + straight steps + 3 per exact corner, and a query stops early at the first
// wall. Probes go one at a time, through the DDA unit's single crossing
// compare and the one bitmap read port. A finished result waits in an output
// register, and writes are still taken while it waits.
// ----------------------------------------------------------------------------
module supercover_line_walkable (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  slw_pkg::coord_t               s_start_x,
    input  slw_pkg::coord_t               s_start_y,
    input  slw_pkg::coord_t               s_end_x,
    input  slw_pkg::coord_t               s_end_y,
    input  logic                          s_cell_walkable,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_line_clear,
    // config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [slw_pkg::PADDR_W-1:0]   paddr,
    input  logic [slw_pkg::PDATA_W-1:0]   pwdata,
    output logic [slw_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import slw_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_MAIN,
        PH_SIDE_A,
        PH_SIDE_B
    } phase_t;

    state_t    state_reg, state_next;
    phase_t    phase_reg, phase_next;
    coord_t    cx_reg, cx_next, cy_reg, cy_next;
    logic      result_reg, result_next;
    logic      m_valid_reg, m_valid_next;
    logic      m_line_clear_reg, m_line_clear_next;
    grid_dim_t gw_reg, gh_reg;

    dda_cmd_t  cmd;
    dda_view_t view;
    coord_t    cur_x, cur_y, nxt_x, nxt_y;
    logic      wr_en, rd_bit, clearing, cell_ok, cfg_wr;

    // bitmap
    slw_bitmap u_bitmap (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_addr  (cell_addr(s_start_x, s_start_y)),
        .wr_bit   (s_cell_walkable),
        .rd_addr  (cell_addr(cx_reg, cy_reg)),
        .rd_bit   (rd_bit),
        .clearing (clearing)
    );

    // stepping unit
    slw_dda u_dda (
        .aclk  (aclk),
        .cmd   (cmd),
        .x0    (s_start_x),
        .y0    (s_start_y),
        .x1    (s_end_x),
        .y1    (s_end_y),
        .cur_x (cur_x),
        .cur_y (cur_y),
        .nxt_x (nxt_x),
        .nxt_y (nxt_y),
        .view  (view)
    );

    // probed cell is open
    assign cell_ok = rd_bit && in_area(cx_reg, cy_reg, gw_reg, gh_reg);

    // sequencer next state
    always_comb begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        cx_next           = cx_reg;
        cy_next           = cy_reg;
        result_next       = result_reg;
        m_valid_next      = m_valid_reg;
        m_line_clear_next = m_line_clear_reg;
        cmd               = '0;
        wr_en             = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                if (!clearing) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    if (s_kind == KIND_QUERY) begin
                        cmd.load   = 1'b1;
                        cx_next    = s_start_x;
                        cy_next    = s_start_y;
                        phase_next = PH_MAIN;
                        state_next = S_READ;
                    end else begin
                        wr_en = in_stored(s_start_x, s_start_y);
                    end
                end
            end
            S_READ: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (!cell_ok) begin
                    result_next = 1'b0;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_READ;
                    unique case (phase_reg)
                        PH_SIDE_A: begin
                            cx_next    = cur_x;
                            cy_next    = nxt_y;
                            phase_next = PH_SIDE_B;
                        end
                        PH_SIDE_B: begin
                            cmd.step_x = 1'b1;
                            cmd.step_y = 1'b1;
                            cx_next    = nxt_x;
                            cy_next    = nxt_y;
                            phase_next = PH_MAIN;
                        end
                        PH_MAIN: begin
                            if (view.done) begin
                                result_next = 1'b1;
                                state_next  = S_DONE;
                            end else if (view.corner) begin
                                cx_next    = nxt_x;
                                cy_next    = cur_y;
                                phase_next = PH_SIDE_A;
                            end else if (view.go_x) begin
                                cmd.step_x = 1'b1;
                                cx_next    = nxt_x;
                                cy_next    = cur_y;
                            end else begin
                                cmd.step_y = 1'b1;
                                cx_next    = cur_x;
                                cy_next    = nxt_y;
                            end
                        end
                        default: begin
                            phase_next = PH_MAIN;
                        end
                    endcase
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_line_clear_next = result_reg;
                    state_next        = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // sequencer state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            phase_reg   <= PH_MAIN;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
        cx_reg           <= cx_next;
        cy_reg           <= cy_next;
        result_reg       <= result_next;
        m_line_clear_reg <= m_line_clear_next;
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_line_clear = m_line_clear_reg;

    // config registers
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gw_reg <= GRID_DIM_RESET;
            gh_reg <= GRID_DIM_RESET;
        end else if (cfg_wr) begin
            if (paddr[PADDR_W-1] == REG_GRID_HEIGHT) begin
                gh_reg <= pwdata[CFG_W-1:0];
            end else begin
                gw_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign prdata = (paddr[PADDR_W-1] == REG_GRID_WIDTH) ? PDATA_W'(gw_reg)
                                                         : PDATA_W'(gh_reg);
    assign pready = 1'b1;

endmodule

// ----- hdl/slw_checker.sv -----
// ----------------------------------------------------------------------------
// slw_checker
// Port-level checks on the line walk block, bound to the top level.
// ----------------------------------------------------------------------------
module slw_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic s_kind,
    input logic m_valid,
    input logic m_ready,
    input logic m_line_clear
);
    import slw_pkg::*;

    // reset starts the clearing sweep and drops any pending result
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block not quiet after reset");

    // a query holds off further requests
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind == KIND_QUERY) |=> !s_ready)
        else $error("request taken while a query is in progress");

    // a cell write keeps the block ready
    a_write_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind == KIND_WRITE) |=> s_ready)
        else $error("cell write stalled the request channel");

    // stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_line_clear))
        else $error("result changed while stalled");

endmodule

bind supercover_line_walkable slw_checker u_slw_checker (.*);
